// ===== rtl/dfr_pkg.sv =====
// dfr_pkg: shared types and constants for the delimited frame receiver
// used by dfr_ctrl, dfr_datapath and delimited_frame_receiver; no dependencies
package dfr_pkg;

	localparam logic [7:0] CH_OPEN  = 8'h3C;
	localparam logic [7:0] CH_CLOSE = 8'h3E;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_EMPTY    = 2'd1,
		KIND_OVERFLOW = 2'd2,
		KIND_TIMEOUT  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RD,
		ST_LOAD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic  capture;
		logic  tick_upd;
		logic  open_frame;
		logic  append;
		logic  drop;
		logic  emit;
		kind_t emit_kind;
		logic  rd_start;
		logic  rd_en;
		logic  load_data;
	} dfr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic is_open;
		logic is_close;
		logic in_frame;
		logic buf_full;
		logic fill_zero;
		logic timeout_hit;
		logic rd_last;
		logic out_free;
	} dfr_status_t;

endpackage

// ===== rtl/dfr_ctrl.sv =====
// dfr_ctrl: state machine that sequences item execution and payload streaming
// depends on dfr_pkg
module dfr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  dfr_pkg::dfr_status_t status,
	output dfr_pkg::dfr_cmd_t    cmd
);
	import dfr_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.emit_kind = KIND_DATA;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.is_tick) begin
					if (status.timeout_hit) begin
						// hold until the output register can take the error
						if (status.out_free) begin
							cmd.tick_upd  = 1'b1;
							cmd.emit      = 1'b1;
							cmd.emit_kind = KIND_TIMEOUT;
							cmd.drop      = 1'b1;
							state_d       = ST_IDLE;
						end
					end else begin
						cmd.tick_upd = 1'b1;
						state_d      = ST_IDLE;
					end
				end else if (status.is_open) begin
					cmd.open_frame = 1'b1;
					state_d        = ST_IDLE;
				end else if (status.is_close) begin
					if (!status.in_frame) begin
						state_d = ST_IDLE;
					end else if (status.fill_zero) begin
						if (status.out_free) begin
							cmd.emit      = 1'b1;
							cmd.emit_kind = KIND_EMPTY;
							cmd.drop      = 1'b1;
							state_d       = ST_IDLE;
						end
					end else begin
						cmd.rd_start = 1'b1;
						state_d      = ST_RD;
					end
				end else if (status.in_frame) begin
					if (status.buf_full) begin
						if (status.out_free) begin
							cmd.emit      = 1'b1;
							cmd.emit_kind = KIND_OVERFLOW;
							cmd.drop      = 1'b1;
							state_d       = ST_IDLE;
						end
					end else begin
						cmd.append = 1'b1;
						state_d    = ST_IDLE;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				if (status.out_free) begin
					cmd.load_data = 1'b1;
					if (status.rd_last) begin
						cmd.drop = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/dfr_datapath.sv =====
// dfr_datapath: frame store, fill and tick counters, timeout register, output register
// depends on dfr_pkg; driven by dfr_ctrl
module dfr_datapath #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dfr_pkg::dfr_cmd_t    cmd,
	output dfr_pkg::dfr_status_t status,
	input  logic                 command,
	input  logic [7:0]           rx_byte,
	input  logic                 cfg_wr_en,
	input  logic [15:0]          cfg_wr_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           kind,
	output logic [7:0]           payload_byte,
	output logic                 last
);
	import dfr_pkg::*;

	localparam int FW = $clog2(BUFFER_BYTES);
	localparam logic [FW-1:0] FILL_MAX = FW'(BUFFER_BYTES - 1);

	logic [7:0]    mem [BUFFER_BYTES];
	logic          cmd_q;
	logic [7:0]    byte_q;
	logic          in_frame_q;
	logic [FW-1:0] fill_q;
	logic [15:0]   elapsed_q;
	logic [15:0]   timeout_q;
	logic [FW-1:0] rd_ptr_q;
	logic [7:0]    rd_data_q;
	logic          out_valid_q;
	kind_t         out_kind_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;
	logic [15:0]   elapsed_inc;

	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;

	always_comb begin
		status.is_tick     = (cmd_q == CMD_TICK);
		status.is_open     = (byte_q == CH_OPEN);
		status.is_close    = (byte_q == CH_CLOSE);
		status.in_frame    = in_frame_q;
		status.buf_full    = (fill_q == FILL_MAX);
		status.fill_zero   = (fill_q == '0);
		status.timeout_hit = in_frame_q && (elapsed_inc > timeout_q);
		status.rd_last     = (rd_ptr_q == fill_q - FW'(1));
		status.out_free    = !out_valid_q || !out_stall;
	end

	// item holding register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= command;
			byte_q <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			fill_q     <= '0;
			elapsed_q  <= '0;
			timeout_q  <= TIMEOUT_RESET;
		end else begin
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
			if (cmd.tick_upd) begin
				elapsed_q <= elapsed_inc;
			end
			if (cmd.open_frame) begin
				in_frame_q <= 1'b1;
				fill_q     <= '0;
				elapsed_q  <= '0;
			end else if (cmd.drop) begin
				in_frame_q <= 1'b0;
				fill_q     <= '0;
			end else if (cmd.append) begin
				fill_q <= fill_q + FW'(1);
			end
		end
	end

	// frame store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			mem[fill_q] <= byte_q;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_start) begin
			rd_ptr_q <= '0;
		end else if (cmd.load_data) begin
			rd_ptr_q <= rd_ptr_q + FW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.load_data) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q <= cmd.emit_kind;
			out_byte_q <= 8'd0;
			out_last_q <= 1'b1;
		end else if (cmd.load_data) begin
			out_kind_q <= KIND_DATA;
			out_byte_q <= rd_data_q;
			out_last_q <= status.rd_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_kind_q;
	assign payload_byte = out_byte_q;
	assign last         = out_last_q;

`ifndef SYNTHESIS
	a_fill_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != '0) |-> in_frame_q)
		else $error("stored bytes with no frame open");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.load_data) |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while stalled");
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> (fill_q != FILL_MAX) && in_frame_q)
		else $error("append into a full store or closed frame");
	a_stream_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_data |=> $stable(fill_q) || !in_frame_q)
		else $error("fill count changed during streaming");
`endif

endmodule

// ===== rtl/delimited_frame_receiver.sv =====
// delimited_frame_receiver: top level joining the controller and the datapath
// depends on dfr_pkg, dfr_ctrl, dfr_datapath
//
// Usage:
//   The input channel (in_valid/in_stall, command, rx_byte) takes one item: a received
//   byte (command 0) or a millisecond tick (command 1). '<' opens a frame, payload
//   bytes are stored, '>' closes the frame and streams the payload out.
//   The output channel (out_valid/out_stall, kind, payload_byte, last) gives payload
//   bytes, an empty-frame marker, or an overflow or timeout error; last marks the
//   final result caused by one input transaction.
//   Timing: an item is executed after it is accepted and may wait while the output
//   register is full; no new item is taken until it is done. A result it causes
//   appears in the output register in the next cycle. A closing '>' streams the
//   stored bytes, each by one frame store read and one output register load.
//   The output register lets the next input transaction be taken while a result
//   still waits. When the receiver stalls, a pending result holds and the block
//   waits before producing the next one; in_stall rises while an item is executed.
//   cfg_wr_en/cfg_wr_data write timeout_ticks (reset 1000).
//   Reset: no frame open, fill and elapsed counters zero, output empty.
module delimited_frame_receiver #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic        last,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);
	import dfr_pkg::*;

	dfr_cmd_t    cmd;
	dfr_status_t status;

	dfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	dfr_datapath #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.command      (command),
		.rx_byte      (rx_byte),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.payload_byte (payload_byte),
		.last         (last)
	);

endmodule
